[rtl/core/xpj_pkg.sv]
package xpj_pkg;

  localparam int DATA_W     = 64;
  localparam int MODE_W     = 3;
  localparam int DIV_CNT_W  = $clog2(DATA_W);
  localparam int LEAP_STEPS = 2 * DATA_W;
  localparam int LEAP_CNT_W = $clog2(LEAP_STEPS);
  localparam int CFG_IDX_W  = 1;

  localparam logic [MODE_W-1:0] MODE_RAW    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_BOUND  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_JUMP   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_LJUMP  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_RESEED = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_SEED_LOW  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEED_HIGH = 1'b1;

  localparam logic [DATA_W-1:0] ALL_ONES      = '1;
  localparam logic [DATA_W-1:0] SEED_LOW_RST  = 64'd1;
  localparam logic [DATA_W-1:0] SEED_HIGH_RST = 64'd0;

  // word 1 in the upper half, stepped from bit 0 upwards
  localparam logic [LEAP_STEPS-1:0] JUMP_POLY =
    {64'h170865df4b3201fc, 64'hdf900294d8f554a5};
  localparam logic [LEAP_STEPS-1:0] LJUMP_POLY =
    {64'hdddf9b1090aa7ac1, 64'hd2a98b26625eee7b};

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIVISOR,
    S_QUOT,
    S_LEAP,
    S_DONE
  } seq_state_t;

  typedef struct packed {
    logic step;
    logic load_seed;
    logic acc_clr;
    logic leap_step;
    logic leap_bit;
    logic leap_last;
  } gen_cmd_t;

endpackage

[rtl/core/xpj_gen.sv]
module xpj_gen (
  input  logic                        clk,
  input  logic                        rst,
  input  xpj_pkg::gen_cmd_t           cmd,
  input  logic [xpj_pkg::DATA_W-1:0]  seed_low,
  input  logic [xpj_pkg::DATA_W-1:0]  seed_high,
  output logic [xpj_pkg::DATA_W-1:0]  sum
);
  import xpj_pkg::*;

  logic [DATA_W-1:0] a, b;
  logic [DATA_W-1:0] acc_a, acc_b;
  logic [DATA_W-1:0] b_mix, a_step, b_step;
  logic [DATA_W-1:0] acc_a_next, acc_b_next;

  always_comb begin
    b_mix      = a ^ b;
    // rotate left 24, shift 16, rotate left 37
    a_step     = {a[39:0], a[63:40]} ^ b_mix ^ (b_mix << 16);
    b_step     = {b_mix[26:0], b_mix[63:27]};
    acc_a_next = acc_a ^ (cmd.leap_bit ? a : '0);
    acc_b_next = acc_b ^ (cmd.leap_bit ? b : '0);
    sum        = a + b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a <= SEED_LOW_RST;
      b <= SEED_HIGH_RST;
    end else if (cmd.load_seed) begin
      a <= seed_low;
      b <= seed_high;
    end else if (cmd.leap_step && cmd.leap_last) begin
      a <= acc_a_next;
      b <= acc_b_next;
    end else if (cmd.step || cmd.leap_step) begin
      a <= a_step;
      b <= b_step;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.acc_clr) begin
      acc_a <= '0;
      acc_b <= '0;
    end else if (cmd.leap_step) begin
      acc_a <= acc_a_next;
      acc_b <= acc_b_next;
    end
  end

endmodule

[rtl/core/xpj_div.sv]
module xpj_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [xpj_pkg::DATA_W-1:0]  dividend,
  input  logic [xpj_pkg::DATA_W-1:0]  divisor,
  output logic                        done,
  output logic [xpj_pkg::DATA_W-1:0]  quotient
);
  import xpj_pkg::*;

  localparam logic [DIV_CNT_W-1:0] CNT_LAST = DIV_CNT_W'(DATA_W - 1);

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DATA_W-1:0]    rem, quo, dvs;
  logic [DATA_W:0]      shifted, diff;
  logic                 ge;

  // restoring division, one quotient bit a cycle
  always_comb begin
    shifted  = {rem, quo[DATA_W-1]};
    diff     = shifted - {1'b0, dvs};
    ge       = (shifted >= {1'b0, dvs});
    quotient = quo;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == CNT_LAST);
      if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_LAST) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      rem <= ge ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
      quo <= {quo[DATA_W-2:0], ge};
    end
  end

endmodule

[rtl/core/xoroshiro_prng_with_jump.sv]
// Raw draw, reseed and unused modes: result word registered on the accepting
// edge, one word per cycle while the output side keeps up.
// Bounded draw: an all-ones limit acts as a raw draw; else a divider pass for
// the divisor, then a pass per draw attempt through the same bit-serial divider,
// then delivery. Jump and long jump: 128 generator steps, one a cycle, then delivery.
// Reset: state words 1 and 0, seed registers 1 and 0, output empty.
module xoroshiro_prng_with_jump (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [xpj_pkg::MODE_W-1:0]     mode,
  input  logic [xpj_pkg::DATA_W-1:0]     limit,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [xpj_pkg::DATA_W-1:0]     value,
  input  logic                           cfg_we,
  input  logic [xpj_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [xpj_pkg::DATA_W-1:0]     cfg_data
);
  import xpj_pkg::*;

  localparam logic [LEAP_CNT_W-1:0] LEAP_LAST = LEAP_CNT_W'(LEAP_STEPS - 1);

  seq_state_t st, st_next;
  gen_cmd_t   cmd;

  logic [DATA_W-1:0]     seed_low, seed_high;
  logic [DATA_W-1:0]     sum;
  logic [DATA_W-1:0]     lim, bdiv, res;
  logic [LEAP_CNT_W-1:0] leap_cnt;
  logic                  leap_long;
  logic [LEAP_STEPS-1:0] poly;

  logic              out_free, out_load, res_load, lim_load, bdiv_load, leap_start;
  logic [DATA_W-1:0] out_data, res_data;
  logic              div_start, div_done;
  logic [DATA_W-1:0] div_a, div_b, div_q;

  xpj_gen u_gen (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .seed_low  (seed_low),
    .seed_high (seed_high),
    .sum       (sum)
  );

  xpj_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quotient (div_q)
  );

  assign out_free = !out_valid || out_ready;
  assign poly     = leap_long ? LJUMP_POLY : JUMP_POLY;

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE;
    end else begin
      st <= st_next;
    end
  end

  always_comb begin
    st_next    = st;
    cmd        = '0;
    in_ready   = 1'b0;
    div_start  = 1'b0;
    div_a      = sum;
    div_b      = bdiv;
    out_load   = 1'b0;
    out_data   = sum;
    res_load   = 1'b0;
    res_data   = div_q;
    lim_load   = 1'b0;
    bdiv_load  = 1'b0;
    leap_start = 1'b0;
    case (st)
      S_IDLE: begin
        in_ready = out_free;
        if (in_valid && out_free) begin
          case (mode)
            MODE_RAW: begin
              cmd.step = 1'b1;
              out_load = 1'b1;
            end
            MODE_BOUND: begin
              if (limit == ALL_ONES) begin
                cmd.step = 1'b1;
                out_load = 1'b1;
              end else begin
                div_start = 1'b1;
                div_a     = ALL_ONES;
                div_b     = limit + 1'b1;
                lim_load  = 1'b1;
                st_next   = S_DIVISOR;
              end
            end
            MODE_JUMP, MODE_LJUMP: begin
              cmd.acc_clr = 1'b1;
              leap_start  = 1'b1;
              st_next     = S_LEAP;
            end
            MODE_RESEED: begin
              cmd.load_seed = 1'b1;
              out_load      = 1'b1;
              out_data      = '0;
            end
            default: begin
              out_load = 1'b1;
              out_data = '0;
            end
          endcase
        end
      end
      S_DIVISOR: begin
        if (div_done) begin
          bdiv_load = 1'b1;
          div_start = 1'b1;
          div_b     = div_q;
          cmd.step  = 1'b1;
          st_next   = S_QUOT;
        end
      end
      S_QUOT: begin
        if (div_done) begin
          if (div_q > lim) begin
            // rejected: redraw
            div_start = 1'b1;
            cmd.step  = 1'b1;
          end else begin
            res_load = 1'b1;
            st_next  = S_DONE;
          end
        end
      end
      S_LEAP: begin
        cmd.leap_step = 1'b1;
        cmd.leap_bit  = poly[leap_cnt];
        cmd.leap_last = (leap_cnt == LEAP_LAST);
        if (leap_cnt == LEAP_LAST) begin
          res_load = 1'b1;
          res_data = '0;
          st_next  = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_load = 1'b1;
          out_data = res;
          st_next  = S_IDLE;
        end
      end
      default: st_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seed_low  <= SEED_LOW_RST;
      seed_high <= SEED_HIGH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SEED_LOW:  seed_low  <= cfg_data;
        CFG_SEED_HIGH: seed_high <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      leap_cnt <= '0;
    end else if (leap_start) begin
      leap_cnt <= '0;
    end else if (st == S_LEAP) begin
      leap_cnt <= leap_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      value <= out_data;
    end
    if (res_load) begin
      res <= res_data;
    end
    if (lim_load) begin
      lim <= limit;
    end
    if (bdiv_load) begin
      bdiv <= div_q;
    end
    if (leap_start) begin
      leap_long <= (mode == MODE_LJUMP);
    end
  end

  a_div_done_in_bound: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (st == S_DIVISOR || st == S_QUOT))
    else $error("divider finished outside a bounded draw");

  a_leap_ends: assert property (@(posedge clk) disable iff (rst)
    (st == S_LEAP && leap_cnt == LEAP_LAST) |=> st == S_DONE)
    else $error("jump sequence did not end after its last step");

  a_jump_starts: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && (mode == MODE_JUMP || mode == MODE_LJUMP))
      |=> (st == S_LEAP && leap_cnt == '0))
    else $error("jump word did not start the step sequence");

endmodule

[dv/xpj_value_checker.sv]
`timescale 1ns / 100ps

module xpj_value_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic [xpj_pkg::MODE_W-1:0]     mode,
  input  logic [xpj_pkg::DATA_W-1:0]     limit,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic [xpj_pkg::DATA_W-1:0]     value,
  input  logic                           cfg_we,
  input  logic [xpj_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [xpj_pkg::DATA_W-1:0]     cfg_data,
  output int unsigned                    values_pending,
  output int unsigned                    value_errors
);
  import xpj_pkg::*;

  localparam int unsigned SHOW_MAX = 10;

  logic [DATA_W-1:0] gen_a, gen_b;
  logic [DATA_W-1:0] seed_lo, seed_hi;
  logic [DATA_W-1:0] values_due [$];

  // one xoroshiro128+ step: returns the sum word, advances the pair
  function automatic logic [DATA_W-1:0] gen_step();
    logic [DATA_W-1:0] a, b, sum;
    a     = gen_a;
    b     = gen_b;
    sum   = a + b;
    b     = b ^ a;
    gen_a = {a[39:0], a[63:40]} ^ b ^ (b << 16);
    gen_b = {b[26:0], b[63:27]};
    return sum;
  endfunction

  function automatic void gen_leap(input logic [LEAP_STEPS-1:0] poly);
    logic [DATA_W-1:0] acc_a, acc_b;
    acc_a = '0;
    acc_b = '0;
    for (int i = 0; i < LEAP_STEPS; i++) begin
      if (poly[i]) begin
        acc_a ^= gen_a;
        acc_b ^= gen_b;
      end
      void'(gen_step());
    end
    gen_a = acc_a;
    gen_b = acc_b;
  endfunction

  // rejection sampling against floor(all-ones / (limit+1))
  function automatic logic [DATA_W-1:0] gen_bounded(input logic [DATA_W-1:0] lim);
    logic [DATA_W-1:0] divisor, quot;
    if (lim == ALL_ONES) return gen_step();
    divisor = ALL_ONES / (lim + 64'd1);
    do begin
      quot = gen_step() / divisor;
    end while (quot > lim);
    return quot;
  endfunction

  function automatic logic [DATA_W-1:0] gen_value(input logic [MODE_W-1:0] m,
                                                  input logic [DATA_W-1:0] lim);
    case (m)
      MODE_RAW:   return gen_step();
      MODE_BOUND: return gen_bounded(lim);
      MODE_JUMP:  gen_leap(JUMP_POLY);
      MODE_LJUMP: gen_leap(LJUMP_POLY);
      MODE_RESEED: begin
        gen_a = seed_lo;
        gen_b = seed_hi;
      end
      default: ;
    endcase
    return '0;
  endfunction

  always @(posedge clk) begin
    logic [DATA_W-1:0] want;
    if (rst) begin
      gen_a   = SEED_LOW_RST;
      gen_b   = SEED_HIGH_RST;
      seed_lo = SEED_LOW_RST;
      seed_hi = SEED_HIGH_RST;
      values_due.delete();
      values_pending = 0;
      value_errors   = 0;
    end else begin
      // retire before accepting: a new request never answers on its own edge
      if (out_valid && out_ready) begin
        if (values_due.size() == 0) begin
          value_errors++;
          if (value_errors <= SHOW_MAX)
            $display("%0t: output word %h with nothing outstanding", $realtime, value);
        end else begin
          want = values_due.pop_front();
          if (value !== want) begin
            value_errors++;
            if (value_errors <= SHOW_MAX)
              $display("%0t: value mismatch, expected %h, got %h", $realtime, want, value);
          end
        end
      end
      if (in_valid && in_ready)
        values_due.push_back(gen_value(mode, limit));
      if (cfg_we) begin
        case (cfg_index)
          CFG_SEED_LOW:  seed_lo = cfg_data;
          CFG_SEED_HIGH: seed_hi = cfg_data;
          default: ;
        endcase
      end
      values_pending = values_due.size();
    end
  end

endmodule

[dv/xoroshiro_prng_with_jump_test.sv]
`timescale 1ns / 100ps

module xoroshiro_prng_with_jump_test;
  import xpj_pkg::*;

  localparam logic [MODE_W-1:0] MODE_SPARE_FIRST = 3'd5;
  localparam logic [MODE_W-1:0] MODE_SPARE_LAST  = 3'd7;
  localparam int unsigned CYCLE_LIMIT     = 1_000_000;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned TAIL_CYCLES     = 300;
  localparam int          RAND_PHASES     = 4;
  localparam int          RAND_PER_PHASE  = 90;

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_ready;
  logic [MODE_W-1:0]    mode;
  logic [DATA_W-1:0]    limit;
  logic                 out_valid;
  logic                 out_ready;
  logic [DATA_W-1:0]    value;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DATA_W-1:0]    cfg_data;

  int unsigned values_pending, value_errors;
  int unsigned cycle_count = 0;
  int unsigned n_raw = 0, n_bound = 0, n_leap = 0, n_reseed = 0, n_spare = 0;
  int unsigned n_settings = 0;

  bit stall_on  = 1'b0;
  bit hold_req  = 1'b0;
  bit hold_done = 1'b0;

  xoroshiro_prng_with_jump DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .mode      (mode),
    .limit     (limit),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .value     (value),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  xpj_value_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .mode           (mode),
    .limit          (limit),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .value          (value),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .values_pending (values_pending),
    .value_errors   (value_errors)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Timeout after %0d cycles, %0d words outstanding", cycle_count, values_pending);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // output side: random stall bursts, plus one long hold-off on request
  initial begin
    out_ready <= 1'b0;
    @(negedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        hold_done = 1'b1;
      end else if (stall_on && $urandom_range(0, 99) < 15) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  function automatic logic [DATA_W-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // bounds spread over magnitudes, at and just below powers of two, and near full range
  function automatic logic [DATA_W-1:0] pick_limit();
    case ($urandom_range(0, 5))
      0:       return 64'($urandom_range(0, 20));
      1:       return rand_word();
      2:       return rand_word() >> $urandom_range(1, 63);
      3:       return (64'd1 << $urandom_range(0, 63)) - 64'($urandom_range(0, 1));
      4:       return ALL_ONES - 64'($urandom_range(0, 1));
      default: return (64'd1 << 63) + 64'($urandom_range(0, 3));
    endcase
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_word(input logic [MODE_W-1:0] m, input logic [DATA_W-1:0] l);
    mode     <= m;
    limit    <= l;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    case (m)
      MODE_RAW:               n_raw++;
      MODE_BOUND:             n_bound++;
      MODE_JUMP, MODE_LJUMP:  n_leap++;
      MODE_RESEED:            n_reseed++;
      default:                n_spare++;
    endcase
    @(negedge clk);
  endtask

  task automatic idle_gap(input int unsigned cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (values_pending != 0);
  endtask

  task automatic write_seeds(input logic [DATA_W-1:0] lo, input logic [DATA_W-1:0] hi);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SEED_LOW;
    cfg_data  <= lo;
    @(negedge clk);
    cfg_index <= CFG_SEED_HIGH;
    cfg_data  <= hi;
    @(negedge clk);
    cfg_we    <= 1'b0;
    n_settings++;
  endtask

  initial begin
    int                pick;
    logic [MODE_W-1:0] m;
    logic [DATA_W-1:0] phase_lo [RAND_PHASES];
    logic [DATA_W-1:0] phase_hi [RAND_PHASES];

    rst       <= 1'b1;
    in_valid  <= 1'b0;
    mode      <= MODE_RAW;
    limit     <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= CFG_SEED_LOW;
    cfg_data  <= '0;
    phase_lo = '{ALL_ONES, rand_word(), '0, rand_word()};
    phase_hi = '{ALL_ONES, rand_word(), rand_word(), '0};
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed, from the reset state
    send_word(MODE_RAW, '0);
    send_word(MODE_RAW, ALL_ONES);
    send_word(MODE_BOUND, '0);
    send_word(MODE_BOUND, ALL_ONES);
    send_word(MODE_BOUND, 64'd1);
    send_word(MODE_BOUND, 64'd1 << 63);
    send_word(MODE_BOUND, ALL_ONES - 64'd1);
    send_word(MODE_JUMP, ALL_ONES);
    send_word(MODE_RAW, '0);
    send_word(MODE_LJUMP, '0);
    send_word(MODE_RAW, '0);
    for (int s = MODE_SPARE_FIRST; s <= MODE_SPARE_LAST; s++)
      send_word(MODE_W'(s), ALL_ONES);
    send_word(MODE_RESEED, ALL_ONES);
    send_word(MODE_RAW, '0);

    // all-zero state: draws stay zero, bounded draw must still finish
    drain_results();
    write_seeds('0, '0);
    send_word(MODE_RESEED, '0);
    send_word(MODE_RAW, '0);
    send_word(MODE_BOUND, 64'd5);
    send_word(MODE_JUMP, '0);
    send_word(MODE_RAW, '0);
    send_word(MODE_LJUMP, '0);
    send_word(MODE_BOUND, ALL_ONES);

    for (int p = 0; p < RAND_PHASES; p++) begin
      drain_results();
      write_seeds(phase_lo[p], phase_hi[p]);
      stall_on = (p != RAND_PHASES - 1);
      if (p == 0) begin
        // back-to-back draws against a stalled output: fills the block
        hold_req = 1'b1;
        repeat (40) send_word(MODE_RAW, rand_word());
      end
      send_word(MODE_RESEED, rand_word());
      for (int k = 0; k < RAND_PER_PHASE; k++) begin
        if (p == 1 && k == RAND_PER_PHASE / 2)
          drain_results();
        if (stall_on && $urandom_range(0, 99) < 20)
          idle_gap($urandom_range(1, 9));
        pick = $urandom_range(0, 99);
        if (pick < 50)      m = MODE_RAW;
        else if (pick < 72) m = MODE_BOUND;
        else if (pick < 80) m = MODE_JUMP;
        else if (pick < 85) m = MODE_LJUMP;
        else if (pick < 92) m = MODE_RESEED;
        else                m = MODE_W'($urandom_range(MODE_SPARE_FIRST, MODE_SPARE_LAST));
        send_word(m, (m == MODE_BOUND) ? pick_limit() : rand_word());
      end
    end

    drain_results();
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("Covered %0d raw, %0d bounded, %0d jump, %0d reseed, %0d unused-mode requests",
             n_raw, n_bound, n_leap, n_reseed, n_spare);
    $display("over %0d seed settings in %0d cycles, output held off %0d cycles once",
             n_settings + 1, cycle_count, HOLD_OFF_CYCLES);
    if (value_errors == 0 && values_pending == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

[filelist.f]
rtl/core/xpj_pkg.sv
rtl/core/xpj_gen.sv
rtl/core/xpj_div.sv
rtl/core/xoroshiro_prng_with_jump.sv
dv/xpj_value_checker.sv
dv/xoroshiro_prng_with_jump_test.sv
